FILE: src/sspg_pkg.sv
// Shared types and constants for the stepper step/direction pulse generator.
`default_nettype none

package sspg_pkg;

    localparam int TARGET_W  = 16;
    localparam int SPEED_W   = 16;
    localparam int POS_OUT_W = 16;
    localparam int LIMIT_W   = 15;
    localparam int STEPS_W   = 17;

    localparam logic [STEPS_W-1:0] STEPS_MAX   = 17'h1FFFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7FFF;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_ABS  = 2'd1,
        FUNC_REL  = 2'd2,
        FUNC_CLR  = 2'd3
    } t_func;

    typedef struct packed {
        t_func                func;
        logic [TARGET_W-1:0]  target;
        logic [SPEED_W-1:0]   speed;
    } t_cmd;

    typedef struct packed {
        logic                 step_out;
        logic                 dir_out;
        logic [POS_OUT_W-1:0] position;
        logic                 busy_res;
        logic                 limit_hit;
        logic                 command_ignored;
    } t_res;

endpackage

`default_nettype wire

FILE: src/sspg_core.sv
// Motion state and per-beat update logic of the step/direction generator.
`default_nettype none

module sspg_core #(
    parameter int POS_WIDTH       = 16,
    parameter int MIN_HALF_PERIOD = 25
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_fire,
    input  wire sspg_pkg::t_cmd                  i_cmd,
    input  wire logic                            i_cfg_we,
    input  wire logic [sspg_pkg::LIMIT_W-1:0]    i_cfg_limit,
    output sspg_pkg::t_res                       o_res
);

    localparam int DW = ((POS_WIDTH > sspg_pkg::TARGET_W) ? POS_WIDTH : sspg_pkg::TARGET_W) + 2;
    localparam logic [sspg_pkg::SPEED_W-1:0] HP_MIN = MIN_HALF_PERIOD[sspg_pkg::SPEED_W-1:0];

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    logic [POS_WIDTH-1:0]             r_pos,    n_pos;
    logic                             r_dir,    n_dir;
    logic [sspg_pkg::STEPS_W-1:0]     r_steps,  n_steps;
    logic [sspg_pkg::SPEED_W-1:0]     r_half,   n_half;
    logic [sspg_pkg::SPEED_W-1:0]     r_timer,  n_timer;
    t_phase                           r_phase,  n_phase;
    logic [sspg_pkg::LIMIT_W-1:0]     r_limit;

    logic                             busy;
    logic [DW-1:0]                    pos_sx;
    logic [DW-1:0]                    tgt_sx;
    logic [DW-1:0]                    move_dist;
    logic [DW-1:0]                    dist_mag;
    logic [sspg_pkg::STEPS_W-1:0]     steps_new;
    logic                             dir_new;
    logic [sspg_pkg::SPEED_W-1:0]     half_new;
    logic [DW-1:0]                    next_pos;
    logic [DW-1:0]                    next_mag;
    logic                             lim_reach;
    t_phase                           phase_a;
    logic [sspg_pkg::SPEED_W-1:0]     timer_a;
    logic [sspg_pkg::SPEED_W-1:0]     timer_inc;
    logic                             lvl;
    logic                             lim;
    logic                             ign;
    logic [DW-1:0]                    pos_zx;

    assign busy   = (r_steps != '0);
    assign pos_sx = {{(DW-POS_WIDTH){r_pos[POS_WIDTH-1]}}, r_pos};
    assign tgt_sx = {{(DW-sspg_pkg::TARGET_W){i_cmd.target[sspg_pkg::TARGET_W-1]}},
                     i_cmd.target};

    // move distance: absolute moves subtract the current position
    assign move_dist = tgt_sx - ((i_cmd.func == sspg_pkg::FUNC_ABS) ? pos_sx : '0);
    assign dist_mag  = move_dist[DW-1] ? (~move_dist + DW'(1)) : move_dist;
    assign steps_new = (dist_mag > DW'(sspg_pkg::STEPS_MAX)) ? sspg_pkg::STEPS_MAX
                                                             : dist_mag[sspg_pkg::STEPS_W-1:0];
    assign dir_new   = move_dist[DW-1] || (move_dist == '0);
    assign half_new  = (i_cmd.speed < HP_MIN) ? HP_MIN : i_cmd.speed;

    // soft limit check on the position the next step would reach
    assign next_pos  = r_dir ? (pos_sx - DW'(1)) : (pos_sx + DW'(1));
    assign next_mag  = next_pos[DW-1] ? (~next_pos + DW'(1)) : next_pos;
    assign lim_reach = (next_mag >= DW'(r_limit));

    always_comb begin
        n_pos     = r_pos;
        n_dir     = r_dir;
        n_steps   = r_steps;
        n_half    = r_half;
        n_timer   = r_timer;
        n_phase   = r_phase;
        phase_a   = r_phase;
        timer_a   = r_timer;
        lvl       = 1'b0;
        lim       = 1'b0;
        ign       = 1'b0;
        timer_inc = '0;
        if (i_cmd.func != sspg_pkg::FUNC_TICK) begin
            if (busy) begin
                ign = 1'b1;
            end else if (i_cmd.func == sspg_pkg::FUNC_CLR) begin
                n_pos = '0;
            end else begin
                n_dir   = dir_new;
                n_steps = steps_new;
                n_half  = half_new;
                n_timer = '0;
                n_phase = PH_IDLE;
            end
            lvl = (n_phase == PH_HIGH);
        end else if (busy) begin
            if (r_phase == PH_IDLE) begin
                if (lim_reach) begin
                    lim     = 1'b1;
                    n_steps = r_steps - 1'b1;
                end else begin
                    phase_a = PH_HIGH;
                    timer_a = '0;
                end
            end
            timer_inc = timer_a + 1'b1;
            if (phase_a == PH_HIGH) begin
                lvl     = 1'b1;
                n_phase = PH_HIGH;
                n_timer = timer_inc;
                if (timer_inc >= r_half) begin
                    n_phase = PH_LOW;
                    n_timer = '0;
                end
            end else if (phase_a == PH_LOW && !lim) begin
                n_timer = timer_inc;
                if (timer_inc >= r_half) begin
                    n_pos   = r_dir ? (r_pos - 1'b1) : (r_pos + 1'b1);
                    n_steps = r_steps - 1'b1;
                    n_phase = PH_IDLE;
                    n_timer = '0;
                end
            end
        end
    end

    assign pos_zx = DW'(n_pos);

    always_comb begin
        o_res.step_out        = lvl;
        o_res.dir_out         = n_dir;
        o_res.position        = pos_zx[sspg_pkg::POS_OUT_W-1:0];
        o_res.busy_res        = (n_steps != '0);
        o_res.limit_hit       = lim;
        o_res.command_ignored = ign;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_dir   <= 1'b0;
            r_steps <= '0;
            r_half  <= HP_MIN;
            r_timer <= '0;
            r_phase <= PH_IDLE;
            r_limit <= sspg_pkg::LIMIT_RESET;
        end else begin
            if (i_fire) begin
                r_pos   <= n_pos;
                r_dir   <= n_dir;
                r_steps <= n_steps;
                r_half  <= n_half;
                r_timer <= n_timer;
                r_phase <= n_phase;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_limit;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/stepper_step_pulse_generator.sv
// A beat is held in the input register, then its result in the result register.
// Throughput: one beat per cycle; the input register and the result register
// each advance whenever the stage after them is empty or being emptied.
// Motion state updates as a beat moves from the input register to the result.
// Synchronous active-low reset empties both registers, clears position and
// steps, sets half period to MIN_HALF_PERIOD and the step limit to 32767.
`default_nettype none

module stepper_step_pulse_generator #(
    parameter int POS_WIDTH       = 16,
    parameter int MIN_HALF_PERIOD = 25
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [sspg_pkg::LIMIT_W-1:0]    i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [1:0]                      i_func,
    input  wire logic signed [15:0]              i_target,
    input  wire logic [15:0]                     i_speed,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_step_out,
    output logic                                 o_dir_out,
    output logic signed [15:0]                   o_position,
    output logic                                 o_busy_res,
    output logic                                 o_limit_hit,
    output logic                                 o_command_ignored
);

    logic             r_in_valid;
    sspg_pkg::t_cmd   r_in;
    logic             r_out_valid;
    sspg_pkg::t_res   r_out;
    sspg_pkg::t_res   res;
    logic             adv;

    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    sspg_core #(
        .POS_WIDTH       (POS_WIDTH),
        .MIN_HALF_PERIOD (MIN_HALF_PERIOD)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (adv),
        .i_cmd       (r_in),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_limit (i_cfg_data),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.func   <= sspg_pkg::t_func'(i_func);
            r_in.target <= i_target;
            r_in.speed  <= i_speed;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_step_out        = r_out.step_out;
    assign o_dir_out         = r_out.dir_out;
    assign o_position        = r_out.position;
    assign o_busy_res        = r_out.busy_res;
    assign o_limit_hit       = r_out.limit_hit;
    assign o_command_ignored = r_out.command_ignored;

`ifndef SYNTHESIS
    a_held_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in))
        else $error("input beat lost while stalled");

    a_skip_no_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_limit_hit && o_step_out))
        else $error("step pulse on a skipped step");

    a_ignore_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_command_ignored |-> o_busy_res && !o_limit_hit)
        else $error("command dropped while idle");
`endif

endmodule

`default_nettype wire
